[src/qrm_pkg.sv]
// Shared constants and pipeline types for the quaternion to rotation matrix block.
package qrm_pkg;

    localparam int unsigned DIV_STEPS = 15;
    localparam int unsigned NORM_W    = 33;
    localparam int unsigned DVS_W     = NORM_W + 1;
    localparam int unsigned NUM_W     = 36;
    localparam int unsigned LANES     = 9;
    localparam logic [15:0] ONE_Q14   = 16'd16384;

    typedef struct packed {
        logic [DVS_W-1:0]     rem;
        logic [DIV_STEPS-1:0] sh;
        logic                 neg;
    } lane_t;

    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [DVS_W-1:0]      dvs;
        lane_t [LANES-1:0]     lane;
    } stage_t;

endpackage

[src/quaternion_to_rotation_matrix.sv]
// Top level: quaternion to Q1.14 rotation matrix, fully pipelined.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid/in_ready, quat_w..quat_z     | in
//  output  | out_valid/out_ready, m00..m22, zero_norm | out
//
// One beat accepted per cycle. Stages: products, norm and numerators, dividend
// set-up, 15 restoring-division steps (one quotient bit each), output clamp
// register. The whole pipe advances together; when the output beat is stalled
// every stage holds. Reset clears the valid bits and the division registers.
module quaternion_to_rotation_matrix
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22,
    output logic               zero_norm
);

    logic en;

    // Stage 1: products
    logic               s1_valid_reg;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    // Stage 2: norm and numerators
    logic                                 s2_valid_reg;
    logic [qrm_pkg::NORM_W-1:0]           n_reg;
    logic [qrm_pkg::NORM_W-1:0]           n_next;
    logic signed [qrm_pkg::NUM_W-1:0]     num_reg  [qrm_pkg::LANES];
    logic signed [qrm_pkg::NUM_W-1:0]     num_next [qrm_pkg::LANES];

    // Stage 3 onwards: division pipe
    qrm_pkg::stage_t s3_next;
    qrm_pkg::stage_t s3_reg;
    qrm_pkg::stage_t div_pipe [qrm_pkg::DIV_STEPS+1];

    // Output register
    logic               out_valid_reg;
    logic               zero_reg;
    logic signed [15:0] m_reg  [qrm_pkg::LANES];
    logic signed [15:0] m_next [qrm_pkg::LANES];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= div_pipe[qrm_pkg::DIV_STEPS].valid;
        end
    end

    // Form the ten products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= quat_w * quat_w;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            yz_reg <= quat_y * quat_z;
            wx_reg <= quat_w * quat_x;
            wy_reg <= quat_w * quat_y;
            wz_reg <= quat_w * quat_z;
        end
    end

    // Sum the norm and build the nine numerators
    always_comb
    begin
        logic signed [qrm_pkg::NUM_W-1:0] nn;
        logic signed [qrm_pkg::NUM_W-1:0] sw, sx, sy, sz;
        logic signed [qrm_pkg::NUM_W-1:0] pxy, pxz, pyz, pwx, pwy, pwz;
        sw  = qrm_pkg::NUM_W'(ww_reg);
        sx  = qrm_pkg::NUM_W'(xx_reg);
        sy  = qrm_pkg::NUM_W'(yy_reg);
        sz  = qrm_pkg::NUM_W'(zz_reg);
        pxy = qrm_pkg::NUM_W'(xy_reg);
        pxz = qrm_pkg::NUM_W'(xz_reg);
        pyz = qrm_pkg::NUM_W'(yz_reg);
        pwx = qrm_pkg::NUM_W'(wx_reg);
        pwy = qrm_pkg::NUM_W'(wy_reg);
        pwz = qrm_pkg::NUM_W'(wz_reg);
        nn  = sw + sx + sy + sz;
        n_next = nn[qrm_pkg::NORM_W-1:0];
        num_next[0] = nn - ((sy + sz) <<< 1);
        num_next[1] = (pxy - pwz) <<< 1;
        num_next[2] = (pxz + pwy) <<< 1;
        num_next[3] = (pxy + pwz) <<< 1;
        num_next[4] = nn - ((sx + sz) <<< 1);
        num_next[5] = (pyz - pwx) <<< 1;
        num_next[6] = (pxz - pwy) <<< 1;
        num_next[7] = (pyz + pwx) <<< 1;
        num_next[8] = nn - ((sx + sy) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            num_reg <= num_next;
        end
    end

    // Set up dividend (|num| * 2^15 + n) and divisor (2n)
    always_comb
    begin
        logic [qrm_pkg::NUM_W-1:0]  mag;
        logic [47:0]                dvd;
        s3_next       = '0;
        s3_next.valid = s2_valid_reg;
        s3_next.zero  = (n_reg == '0);
        s3_next.dvs   = {n_reg, 1'b0};
        for (int i = 0; i < qrm_pkg::LANES; i++)
        begin
            mag = num_reg[i][qrm_pkg::NUM_W-1] ? qrm_pkg::NUM_W'(-num_reg[i])
                                               : qrm_pkg::NUM_W'(num_reg[i]);
            dvd = {mag[qrm_pkg::NORM_W-1:0], 15'd0} + {15'd0, n_reg};
            s3_next.lane[i].neg = num_reg[i][qrm_pkg::NUM_W-1];
            s3_next.lane[i].rem = {1'b0, dvd[47:15]};
            s3_next.lane[i].sh  = dvd[14:0];
        end
    end

    // Advance the divider entry register; clear it under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    // Division steps, one quotient bit per stage
    assign div_pipe[0] = s3_reg;

    for (genvar g = 0; g < qrm_pkg::DIV_STEPS; g++)
    begin : g_div
        qrm_div_stage u_step
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (div_pipe[g]),
            .d_out (div_pipe[g+1])
        );
    end

    // Clamp, apply sign, substitute identity for a zero quaternion
    always_comb
    begin
        logic [15:0] q;
        for (int i = 0; i < qrm_pkg::LANES; i++)
        begin
            q = {1'b0, div_pipe[qrm_pkg::DIV_STEPS].lane[i].sh};
            if (q > qrm_pkg::ONE_Q14)
            begin
                q = qrm_pkg::ONE_Q14;
            end
            if (div_pipe[qrm_pkg::DIV_STEPS].zero)
            begin
                m_next[i] = (i % 4 == 0) ? $signed(qrm_pkg::ONE_Q14) : 16'sd0;
            end
            else if (div_pipe[qrm_pkg::DIV_STEPS].lane[i].neg)
            begin
                m_next[i] = $signed(-q);
            end
            else
            begin
                m_next[i] = $signed(q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m_next;
            zero_reg <= div_pipe[qrm_pkg::DIV_STEPS].zero;
        end
    end

    assign out_valid = out_valid_reg;
    assign zero_norm = zero_reg;
    assign m00 = m_reg[0];
    assign m01 = m_reg[1];
    assign m02 = m_reg[2];
    assign m10 = m_reg[3];
    assign m11 = m_reg[4];
    assign m12 = m_reg[5];
    assign m20 = m_reg[6];
    assign m21 = m_reg[7];
    assign m22 = m_reg[8];

    // Zero quaternion delivers the identity matrix
    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> m00 == 16'sd16384 && m11 == 16'sd16384 &&
        m22 == 16'sd16384 && m01 == 16'sd0 && m12 == 16'sd0 && m20 == 16'sd0)
        else $error("zero quaternion did not give identity");

    // Diagonal elements stay within +-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> m00 >= -16'sd16384 && m00 <= 16'sd16384 &&
        m11 >= -16'sd16384 && m11 <= 16'sd16384 &&
        m22 >= -16'sd16384 && m22 <= 16'sd16384)
        else $error("matrix element out of range");

    // Zero flag at the divider entry matches a zero divisor
    a_zero_dvs: assert property (@(posedge clk) disable iff (!rst_n)
        s3_reg.valid |-> (s3_reg.zero == (s3_reg.dvs == '0)))
        else $error("zero flag and divisor disagree");

endmodule

[src/qrm_div_stage.sv]
// One registered restoring-division step for all nine matrix lanes.
module qrm_div_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  qrm_pkg::stage_t  d_in,
    output qrm_pkg::stage_t  d_out
);

    qrm_pkg::stage_t stage_next;
    qrm_pkg::stage_t stage_reg;

    // Shift in one dividend bit, subtract divisor when it fits
    always_comb
    begin
        logic [qrm_pkg::DVS_W:0] t;
        logic                    ge;
        stage_next = d_in;
        for (int i = 0; i < qrm_pkg::LANES; i++)
        begin
            t  = {d_in.lane[i].rem, d_in.lane[i].sh[qrm_pkg::DIV_STEPS-1]};
            ge = (t >= {1'b0, d_in.dvs});
            if (ge)
            begin
                stage_next.lane[i].rem = qrm_pkg::DVS_W'(t - {1'b0, d_in.dvs});
            end
            else
            begin
                stage_next.lane[i].rem = t[qrm_pkg::DVS_W-1:0];
            end
            stage_next.lane[i].sh = {d_in.lane[i].sh[qrm_pkg::DIV_STEPS-2:0], ge};
        end
    end

    // Advance the step register; clear it under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign d_out = stage_reg;

endmodule
